// ===== rtl/ppc_pkg.sv =====
package ppc_pkg;

  localparam int FT_BITS   = 20;
  localparam int GAIN_BITS = 16;
  localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd1311;

  localparam int PC_W = 3;

  typedef enum logic [2:0] {
    OP_SCH_MUL,
    OP_SCH_DONE,
    OP_MEA_SETUP,
    OP_MEA_DIV,
    OP_MEA_ERR,
    OP_MEA_MUL,
    OP_MEA_DONE,
    OP_MEA_ZERO
  } ppc_op_e;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_NOPER,
    COND_MORE
  } ppc_cond_e;

  localparam logic [PC_W-1:0] STEP_SCH_MUL   = 3'd0;
  localparam logic [PC_W-1:0] STEP_SCH_DONE  = 3'd1;
  localparam logic [PC_W-1:0] STEP_MEA_SETUP = 3'd2;
  localparam logic [PC_W-1:0] STEP_MEA_DIV   = 3'd3;
  localparam logic [PC_W-1:0] STEP_MEA_ERR   = 3'd4;
  localparam logic [PC_W-1:0] STEP_MEA_MUL   = 3'd5;
  localparam logic [PC_W-1:0] STEP_MEA_DONE  = 3'd6;
  localparam logic [PC_W-1:0] STEP_MEA_ZERO  = 3'd7;

  typedef struct packed {
    ppc_op_e         op;
    ppc_cond_e       cond;
    logic [PC_W-1:0] target;
    logic            load_cnt;
    logic            done;
  } ppc_word_t;

  // sequencer -> datapath
  typedef struct packed {
    logic    en;
    ppc_op_e op;
  } ppc_ctrl_t;

  // datapath -> sequencer
  typedef struct packed {
    logic per_zero;
    logic out_free;
  } ppc_stat_t;

  // microcode ROM
  function automatic ppc_word_t prog_word(input logic [PC_W-1:0] pc);
    ppc_word_t w;
    w = '{op: OP_MEA_ZERO, cond: COND_NONE, target: STEP_SCH_MUL, load_cnt: 1'b0, done: 1'b1};
    case (pc)
      STEP_SCH_MUL: begin
        w = '{op: OP_SCH_MUL, cond: COND_NONE, target: STEP_SCH_MUL,
              load_cnt: 1'b0, done: 1'b0};
      end
      STEP_SCH_DONE: begin
        w = '{op: OP_SCH_DONE, cond: COND_NONE, target: STEP_SCH_MUL,
              load_cnt: 1'b0, done: 1'b1};
      end
      STEP_MEA_SETUP: begin
        w = '{op: OP_MEA_SETUP, cond: COND_NOPER, target: STEP_MEA_ZERO,
              load_cnt: 1'b1, done: 1'b0};
      end
      STEP_MEA_DIV: begin
        w = '{op: OP_MEA_DIV, cond: COND_MORE, target: STEP_MEA_DIV,
              load_cnt: 1'b0, done: 1'b0};
      end
      STEP_MEA_ERR: begin
        w = '{op: OP_MEA_ERR, cond: COND_NONE, target: STEP_SCH_MUL,
              load_cnt: 1'b0, done: 1'b0};
      end
      STEP_MEA_MUL: begin
        w = '{op: OP_MEA_MUL, cond: COND_NONE, target: STEP_SCH_MUL,
              load_cnt: 1'b0, done: 1'b0};
      end
      STEP_MEA_DONE: begin
        w = '{op: OP_MEA_DONE, cond: COND_NONE, target: STEP_SCH_MUL,
              load_cnt: 1'b0, done: 1'b1};
      end
      STEP_MEA_ZERO: begin
        w = '{op: OP_MEA_ZERO, cond: COND_NONE, target: STEP_SCH_MUL,
              load_cnt: 1'b0, done: 1'b1};
      end
      default: begin
        w = '{op: OP_MEA_ZERO, cond: COND_NONE, target: STEP_SCH_MUL,
              load_cnt: 1'b0, done: 1'b1};
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/ppc_sequencer.sv =====
module ppc_sequencer #(
  parameter int ITERS = 33
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              start_cmd_i,
  input  ppc_pkg::ppc_stat_t stat_i,
  output logic              busy_o,
  output ppc_pkg::ppc_ctrl_t ctrl_o
);
  import ppc_pkg::*;

  localparam int CNT_W = $clog2(ITERS + 1);

  logic            busy_q;
  logic [PC_W-1:0] pc_q, pc_d;
  logic [CNT_W-1:0] cnt_q;
  ppc_word_t       word;
  logic            en;
  logic            taken;

  assign word = prog_word(pc_q);
  // a step that emits a result waits for a free output slot
  assign en   = busy_q && (!word.done || stat_i.out_free);

  always_comb begin
    case (word.cond)
      COND_NOPER: taken = stat_i.per_zero;
      COND_MORE:  taken = (cnt_q != CNT_W'(1));
      default:    taken = 1'b0;
    endcase
    pc_d = taken ? word.target : pc_q + PC_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= STEP_SCH_MUL;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      pc_q   <= start_cmd_i ? STEP_MEA_SETUP : STEP_SCH_MUL;
    end else if (en) begin
      pc_q <= pc_d;
      if (word.done) begin
        busy_q <= 1'b0;
      end
      if (word.load_cnt) begin
        cnt_q <= CNT_W'(ITERS);
      end else if (word.cond == COND_MORE) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  assign busy_o    = busy_q;
  assign ctrl_o.en = en;
  assign ctrl_o.op = word.op;

endmodule

// ===== rtl/present_phase_corrector.sv =====
// Present phase corrector.
// Input channel (in_valid_i / in_stall_o): cmd_i 0 schedules a frame at
// present_time_i with period frame_time_i, cmd_i 1 reports measured_clock_i.
// Output channel (out_valid_o / out_stall_i): one result per item with the
// wait time, the wrapped phase error, the correction and the used flag.
// Config channel (cfg_valid_i / cfg_ready_o): writes loop_gain; always ready.
// A small microcode ROM steps a shared multiplier and a radix-4 restoring
// divider. Schedule takes 2 steps; measure takes 4 + DIV_ITERS steps, where
// DIV_ITERS = (TIME_BITS + FRAC_BITS + 2) / 2 (33 at defaults) for the
// divide of the clock distance by the frame period, two quotient bits a step.
// A measure with no scheduled period runs only the setup and zero steps.
// In stalls from the cycle after accept until the result is written, so an
// item is taken only once the last one is through. The result sits in an
// output register; the next item is accepted while it waits. If the receiver
// stalls, the final step of the following item holds until that register frees.
// Reset clears the correction, the scheduled time and period (smoothing
// off) and loads the gain with its default.
module present_phase_corrector #(
  parameter int TIME_BITS = 48,
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          cmd_i,
  input  logic [TIME_BITS-1:0]          present_time_i,
  input  logic [ppc_pkg::FT_BITS-1:0]   frame_time_i,
  input  logic [TIME_BITS-1:0]          measured_clock_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [TIME_BITS-1:0]          wait_time_o,
  output logic signed [FRAC_BITS+1:0]   phase_error_o,
  output logic signed [FRAC_BITS:0]     correction_o,
  output logic                          error_used_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ppc_pkg::GAIN_BITS-1:0] cfg_loop_gain_i
);
  import ppc_pkg::*;

  localparam int T         = TIME_BITS;
  localparam int F         = FRAC_BITS;
  localparam int CORR_W    = F + 1;
  localparam int ERR_W     = F + 2;
  localparam int QW        = F + 2;
  localparam int PROD_W    = F + FT_BITS;
  localparam int ADJ_W     = FT_BITS + 1;
  localparam int NUM_W     = T + F + 1;
  localparam int DIV_ITERS = (NUM_W + 1) / 2;
  localparam int DIV_W     = 2 * DIV_ITERS;
  localparam int HALF      = 1 << (F - 1);
  localparam int ONE       = 1 << F;

  localparam logic signed [ERR_W-1:0] HALF_E = ERR_W'(HALF);
  localparam logic signed [ERR_W-1:0] ONE_E  = ERR_W'(ONE);

  // state
  logic [GAIN_BITS-1:0]     gain_q;
  logic signed [CORR_W-1:0] corr_q;
  logic [T-1:0]             sched_time_q;
  logic [FT_BITS-1:0]       sched_per_q;

  // item and work registers
  logic [T-1:0]             pt_q, mc_q;
  logic [FT_BITS-1:0]       ft_q;
  logic                     neg_q;
  logic [DIV_W-1:0]         num_q;
  logic [FT_BITS-1:0]       rem_q;
  logic [QW-1:0]            quo_q;
  logic                     big_q;
  logic signed [ERR_W-1:0]  err_q;
  logic [PROD_W-1:0]        prod_q;

  // output register
  logic                     out_valid_q;
  logic [T-1:0]             wait_q;
  logic signed [ERR_W-1:0]  perr_q;
  logic signed [CORR_W-1:0] corr_out_q;
  logic                     used_q;

  ppc_ctrl_t ctrl;
  ppc_stat_t stat;
  logic      busy;
  logic      accept;

  assign accept        = in_valid_i && !busy;
  assign stat.per_zero = (sched_per_q == '0);
  assign stat.out_free = !out_valid_q || !out_stall_i;

  ppc_sequencer #(
    .ITERS (DIV_ITERS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .start_cmd_i (cmd_i),
    .stat_i      (stat),
    .busy_o      (busy),
    .ctrl_o      (ctrl)
  );

  // ---------------- shared multiplier
  logic [CORR_W-1:0]  corr_abs;
  logic [ERR_W-1:0]   err_abs;
  logic               win;
  logic [F-1:0]       mul_a;
  logic [FT_BITS-1:0] mul_b;
  logic [PROD_W-1:0]  mul_p;

  assign corr_abs = corr_q[CORR_W-1] ? CORR_W'(-corr_q) : CORR_W'(corr_q);
  assign err_abs  = err_q[ERR_W-1] ? ERR_W'(-err_q) : ERR_W'(err_q);
  assign win      = (err_abs <= ERR_W'(HALF));
  assign mul_a    = (ctrl.op == OP_SCH_MUL) ? corr_abs[F-1:0] : err_abs[F-1:0];
  assign mul_b    = (ctrl.op == OP_SCH_MUL) ? ft_q : FT_BITS'(gain_q);
  assign mul_p    = PROD_W'(mul_a) * PROD_W'(mul_b);

  // ---------------- schedule: wait time
  logic [PROD_W:0] adj_sum;
  logic [ADJ_W-1:0] adj;
  logic [T-1:0]    adj_t;
  logic [T:0]      up_sum;
  logic [T-1:0]    sched_wait;

  assign adj_sum = {1'b0, prod_q} + (PROD_W + 1)'(HALF);
  assign adj     = adj_sum[F +: ADJ_W];
  assign adj_t   = T'(adj);
  assign up_sum  = {1'b0, pt_q} + {1'b0, adj_t};

  always_comb begin
    if (ft_q == '0) begin
      sched_wait = pt_q;
    end else if (corr_q[CORR_W-1]) begin
      sched_wait = (adj_t > pt_q) ? '0 : pt_q - adj_t;
    end else begin
      sched_wait = up_sum[T] ? '1 : up_sum[T-1:0];
    end
  end

  // ---------------- measure: distance and divider
  logic             mc_lt;
  logic [T-1:0]     clk_gap;
  logic [NUM_W-1:0] num_init;

  assign mc_lt    = (mc_q < sched_time_q);
  assign clk_gap  = mc_lt ? sched_time_q - mc_q : mc_q - sched_time_q;
  // (clk_gap << F) + per/2, divided by per, gives whole frames and rounded fraction
  assign num_init = NUM_W'({clk_gap, {F{1'b0}}}) + NUM_W'(sched_per_q[FT_BITS-1:1]);

  logic [FT_BITS:0]   r1, r1s, r2, r2s;
  logic               ge1, ge2;
  logic [FT_BITS-1:0] r1n;

  always_comb begin
    r1  = {rem_q, num_q[DIV_W-1]};
    ge1 = (r1 >= {1'b0, sched_per_q});
    r1s = ge1 ? r1 - {1'b0, sched_per_q} : r1;
    r1n = r1s[FT_BITS-1:0];
    r2  = {r1n, num_q[DIV_W-2]};
    ge2 = (r2 >= {1'b0, sched_per_q});
    r2s = ge2 ? r2 - {1'b0, sched_per_q} : r2;
  end

  // ---------------- measure: phase error with frame wrap
  logic [F-1:0]     qlo, wl_pos, wl_neg;
  logic             pos_in, neg_in;
  logic [ERR_W-1:0] err_calc;

  assign qlo    = quo_q[F-1:0];
  assign pos_in = !big_q && (quo_q <= QW'(ONE + HALF));
  assign neg_in = !big_q && (quo_q <= QW'(ONE - HALF));
  assign wl_pos = qlo - F'(HALF) - F'(1);
  assign wl_neg = qlo + F'(HALF) - F'(1);

  always_comb begin
    if (!neg_q) begin
      err_calc = pos_in ? ERR_W'(quo_q) - ERR_W'(HALF)
                        : ERR_W'(wl_pos) + ERR_W'(1);
    end else begin
      err_calc = neg_in ? ERR_W'(0) - ERR_W'(quo_q) - ERR_W'(HALF)
                        : ERR_W'(0) - ERR_W'(wl_neg) - ERR_W'(1);
    end
  end

  // ---------------- measure: correction update
  logic [PROD_W:0]          d_sum;
  logic [F-1:0]             dmag;
  logic signed [ERR_W-1:0]  c_raw, c_wrap;
  logic signed [CORR_W-1:0] corr_new;

  assign d_sum = {1'b0, prod_q} + (PROD_W + 1)'(1 << (GAIN_BITS - 1));
  assign dmag  = d_sum[GAIN_BITS +: F];

  always_comb begin
    c_raw = err_q[ERR_W-1] ? {corr_q[CORR_W-1], corr_q} - ERR_W'(dmag)
                           : {corr_q[CORR_W-1], corr_q} + ERR_W'(dmag);
    if (c_raw > HALF_E) begin
      c_wrap = c_raw - ONE_E;
    end else if (c_raw < -HALF_E) begin
      c_wrap = c_raw + ONE_E;
    end else begin
      c_wrap = c_raw;
    end
    corr_new = c_wrap[CORR_W-1:0];
  end

  // ---------------- control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q       <= GAIN_RESET;
      corr_q       <= '0;
      sched_time_q <= '0;
      sched_per_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        gain_q <= cfg_loop_gain_i;
      end
      if (ctrl.en && ctrl.op == OP_SCH_DONE) begin
        sched_time_q <= sched_wait;
        sched_per_q  <= ft_q;
      end
      if (ctrl.en && ctrl.op == OP_MEA_DONE && win) begin
        corr_q <= corr_new;
      end
      if (ctrl.en && (ctrl.op == OP_SCH_DONE || ctrl.op == OP_MEA_DONE ||
                      ctrl.op == OP_MEA_ZERO)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------- datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pt_q <= present_time_i;
      ft_q <= frame_time_i;
      mc_q <= measured_clock_i;
    end
    if (ctrl.en) begin
      case (ctrl.op)
        OP_SCH_MUL: begin
          prod_q <= mul_p;
        end
        OP_SCH_DONE: begin
          wait_q     <= sched_wait;
          perr_q     <= '0;
          corr_out_q <= corr_q;
          used_q     <= 1'b0;
        end
        OP_MEA_SETUP: begin
          neg_q <= mc_lt;
          num_q <= DIV_W'(num_init);
          rem_q <= '0;
          quo_q <= '0;
          big_q <= 1'b0;
        end
        OP_MEA_DIV: begin
          rem_q <= r2s[FT_BITS-1:0];
          num_q <= num_q << 2;
          quo_q <= {quo_q[QW-3:0], ge1, ge2};
          big_q <= big_q | quo_q[QW-1] | quo_q[QW-2];
        end
        OP_MEA_ERR: begin
          err_q <= err_calc;
        end
        OP_MEA_MUL: begin
          prod_q <= mul_p;
        end
        OP_MEA_DONE: begin
          wait_q     <= '0;
          perr_q     <= err_q;
          corr_out_q <= win ? corr_new : corr_q;
          used_q     <= win;
        end
        OP_MEA_ZERO: begin
          wait_q     <= '0;
          perr_q     <= '0;
          corr_out_q <= corr_q;
          used_q     <= 1'b0;
        end
        default: begin
          used_q <= 1'b0;
        end
      endcase
    end
  end

  assign in_stall_o    = busy;
  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign wait_time_o   = wait_q;
  assign phase_error_o = perr_q;
  assign correction_o  = corr_out_q;
  assign error_used_o  = used_q;

endmodule

// ===== rtl/ppc_checker.sv =====
module ppc_checker #(
  parameter int TIME_BITS = 48,
  parameter int FRAC_BITS = 16
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [TIME_BITS-1:0]        wait_time_o,
  input logic signed [FRAC_BITS+1:0] phase_error_o,
  input logic signed [FRAC_BITS:0]   correction_o,
  input logic                        error_used_o
);

  localparam int HALF = 1 << (FRAC_BITS - 1);

  // protocol: a stalled result stays and holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(wait_time_o)
      && $stable(correction_o))
    else $error("stalled result dropped or changed");

  // the block works on one item at a time
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item accepted while previous one in work");

  // a nonzero wait time only comes from a schedule item
  a_sched_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (wait_time_o != '0) |-> (phase_error_o == '0) && !error_used_o)
    else $error("schedule result carries measure fields");

  // correction stays within half a frame
  a_corr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(correction_o) <= HALF) && ($signed(correction_o) >= -HALF))
    else $error("correction out of range");

endmodule

bind present_phase_corrector ppc_checker #(
  .TIME_BITS (TIME_BITS),
  .FRAC_BITS (FRAC_BITS)
) u_ppc_checker (.*);

// ===== sim/tb_present_phase_corrector.sv =====
module tb_present_phase_corrector;
  import ppc_pkg::*;

  localparam int TIME_W = 48;
  localparam int FRAC_W = 16;
  localparam logic CMD_SCHEDULE = 1'b0;
  localparam logic CMD_MEASURE  = 1'b1;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam longint ONE_FRAME  = 64'sd65536;
  localparam longint HALF_FRAME = 64'sd32768;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [TIME_W-1:0]  wait_t;
    logic signed [17:0] err;
    logic signed [16:0] corr;
    logic               used;
  } frame_outcome_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic                     cmd_i;
  logic [TIME_W-1:0]        present_time_i;
  logic [FT_BITS-1:0]       frame_time_i;
  logic [TIME_W-1:0]        measured_clock_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [TIME_W-1:0]        wait_time_o;
  logic signed [FRAC_W+1:0] phase_error_o;
  logic signed [FRAC_W:0]   correction_o;
  logic                     error_used_o;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [GAIN_BITS-1:0]     cfg_loop_gain_i;

  // model state of the corrector
  logic [GAIN_BITS-1:0] gain_m;
  int                   corr_m;
  logic [TIME_W-1:0]    sched_time_m;
  int unsigned          sched_per_m;

  frame_outcome_t awaited_outcomes[$];
  int  mismatches;
  int  quiet_cycles;
  bit  no_idle;

  present_phase_corrector dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cmd_i            (cmd_i),
    .present_time_i   (present_time_i),
    .frame_time_i     (frame_time_i),
    .measured_clock_i (measured_clock_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .wait_time_o      (wait_time_o),
    .phase_error_o    (phase_error_o),
    .correction_o     (correction_o),
    .error_used_o     (error_used_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_loop_gain_i  (cfg_loop_gain_i)
  );

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  function automatic logic [TIME_W-1:0] rand_time();
    return TIME_W'({$urandom, $urandom});
  endfunction

  // Works out the result of one accepted item and advances the model state.
  function automatic void correct_phase(input logic cmd, input logic [TIME_W-1:0] pt,
                                        input logic [FT_BITS-1:0] ft,
                                        input logic [TIME_W-1:0] mc);
    frame_outcome_t  o;
    longint unsigned cmag, adj, clk, clk_gap, per, whole, rem, frac, mag, emag, dmag;
    longint          e, c;
    bit              neg;
    o = '0;
    if (cmd == CMD_SCHEDULE) begin
      o.wait_t = pt;
      if (ft != 0) begin
        neg = corr_m < 0;
        cmag = longint'(neg ? -corr_m : corr_m);
        adj = (cmag * ft + 64'd32768) >> FRAC_W;
        if (neg)
          o.wait_t = (adj > pt) ? '0 : TIME_W'(pt - adj);
        else
          o.wait_t = (adj > TIME_MAX - pt) ? TIME_MAX : TIME_W'(pt + adj);
      end
      sched_time_m = o.wait_t;
      sched_per_m = 32'(ft);
    end else if (sched_per_m != 0) begin
      clk = mc;
      neg = clk < sched_time_m;
      clk_gap = neg ? sched_time_m - clk : clk - sched_time_m;
      per = sched_per_m;
      whole = clk_gap / per;
      rem = clk_gap % per;
      if (whole > 4) whole = 4;
      frac = ((rem << FRAC_W) + per / 2) / per;
      mag = (whole << FRAC_W) + frac;
      e = longint'(mag);
      if (neg) e = -e;
      e = e - HALF_FRAME;
      while (e > ONE_FRAME) e = e - ONE_FRAME;
      while (e < -ONE_FRAME) e = e + ONE_FRAME;
      o.err = 18'(e);
      if (e <= HALF_FRAME && e >= -HALF_FRAME) begin
        emag = (e < 0) ? -e : e;
        dmag = (emag * gain_m + 64'd32768) >> GAIN_BITS;
        c = longint'(corr_m) + ((e < 0) ? -longint'(dmag) : longint'(dmag));
        while (c > HALF_FRAME) c = c - ONE_FRAME;
        while (c < -HALF_FRAME) c = c + ONE_FRAME;
        corr_m = int'(c);
        o.used = 1'b1;
      end
    end
    o.corr = 17'(corr_m);
    awaited_outcomes.push_back(o);
  endfunction

  // Called at a falling edge, returns at a falling edge with valid still high.
  task automatic send_item(input logic cmd, input logic [TIME_W-1:0] pt,
                           input logic [FT_BITS-1:0] ft, input logic [TIME_W-1:0] mc);
    while (!no_idle && $urandom_range(99) < 25) begin
      in_valid_i = 1'b0;
      cmd_i = 1'($urandom);
      @(negedge clk_i);
    end
    cmd_i = cmd;
    present_time_i = pt;
    frame_time_i = ft;
    measured_clock_i = mc;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    correct_phase(cmd, pt, ft, mc);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i = 1'b0;
    wait (awaited_outcomes.size() == 0);
    @(negedge clk_i);
  endtask

  task automatic write_gain(input logic [GAIN_BITS-1:0] g);
    drain_results();
    repeat (4) @(negedge clk_i);
    cfg_loop_gain_i = g;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    gain_m = g;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // A measure with the clock near the last scheduled time, a few frames off.
  task automatic send_locked_measure();
    longint unsigned per;
    longint          off;
    per = (sched_per_m == 0) ? 1000 : sched_per_m;
    off = longint'($urandom_range(0, 32'(4 * per))) - longint'(per);
    send_item(CMD_MEASURE, rand_time(), FT_BITS'($urandom), TIME_W'(sched_time_m + off));
  endtask

  task automatic test_smoothing_off();
    send_item(CMD_MEASURE, rand_time(), FT_BITS'($urandom), rand_time());
    send_item(CMD_SCHEDULE, rand_time(), '0, rand_time());
    send_item(CMD_MEASURE, rand_time(), FT_BITS'($urandom), rand_time());
    send_item(CMD_MEASURE, rand_time(), FT_BITS'($urandom), sched_time_m);
  endtask

  task automatic test_time_extremes();
    send_item(CMD_SCHEDULE, TIME_MAX, '1, '0);
    send_item(CMD_MEASURE, '0, '0, '0);
    send_item(CMD_MEASURE, '1, '1, TIME_MAX);
    send_item(CMD_SCHEDULE, '0, 20'd1, '1);
    send_item(CMD_MEASURE, '0, '0, TIME_MAX);
    // distance of one and a half frames: error of exactly one frame, dropped
    send_item(CMD_SCHEDULE, '0, 20'd2, '0);
    send_item(CMD_MEASURE, '0, '0, sched_time_m + 3);
    send_item(CMD_MEASURE, '0, '0, sched_time_m + 2);
  endtask

  task automatic test_loop_gain();
    write_gain('1);
    send_item(CMD_SCHEDULE, 48'd1000000, 20'd1000, '0);
    // error of exactly plus one half, twice: the correction wraps
    send_item(CMD_MEASURE, '0, '0, sched_time_m + 1000);
    send_item(CMD_MEASURE, '0, '0, sched_time_m + 1000);
    // error of minus one half pulls the correction negative
    send_item(CMD_MEASURE, '0, '0, sched_time_m);
    // wait time saturates at zero
    send_item(CMD_SCHEDULE, 48'd5, 20'd1000, '0);
    send_item(CMD_MEASURE, '0, '0, sched_time_m + 1000);
    // correction positive again: wait time saturates at the top
    send_item(CMD_SCHEDULE, TIME_MAX, 20'd1000, '0);
    write_gain('0);
    send_item(CMD_SCHEDULE, rand_time(), 20'd1000, '0);
    send_item(CMD_MEASURE, '0, '0, sched_time_m + 200);
  endtask

  task automatic test_random_traffic();
    int r;
    for (int phase = 0; phase < 6; phase++) begin
      write_gain(phase == 0 ? GAIN_RESET : GAIN_BITS'($urandom));
      no_idle = (phase == 2);
      for (int i = 0; i < 150; i++) begin
        if (phase == 3 && i % 30 == 0) drain_results();
        r = $urandom_range(99);
        if (r < 40) begin
          r = $urandom_range(99);
          send_item(CMD_SCHEDULE, rand_time(),
                    (r < 5) ? '0 : (r < 25) ? FT_BITS'($urandom)
                                            : FT_BITS'($urandom_range(1, 50000)),
                    rand_time());
        end else if (r < 90) begin
          send_locked_measure();
        end else begin
          send_item(CMD_MEASURE, rand_time(), FT_BITS'($urandom), rand_time());
        end
      end
      no_idle = 1'b0;
    end
  endtask

  // receiver stalls
  always @(negedge clk_i) begin
    out_stall_i = !no_idle && ($urandom_range(99) < 25);
  end

  always @(posedge clk_i) begin
    frame_outcome_t exp_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_outcomes.size() == 0) begin
        $error("unexpected result: wait_time %0d", wait_time_o);
        mismatches++;
      end else begin
        exp_o = awaited_outcomes.pop_front();
        if (wait_time_o !== exp_o.wait_t) begin
          $error("wait_time: expected %0d, got %0d", exp_o.wait_t, wait_time_o);
          mismatches++;
        end
        if (phase_error_o !== exp_o.err) begin
          $error("phase_error: expected %0d, got %0d", exp_o.err, phase_error_o);
          mismatches++;
        end
        if (correction_o !== exp_o.corr) begin
          $error("correction: expected %0d, got %0d", exp_o.corr, correction_o);
          mismatches++;
        end
        if (error_used_o !== exp_o.used) begin
          $error("error_used: expected %0d, got %0d", exp_o.used, error_used_o);
          mismatches++;
        end
      end
    end
  end

  // watchdog: cycles in which nothing moves on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    cmd_i = 1'b0;
    present_time_i = '0;
    frame_time_i = '0;
    measured_clock_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_loop_gain_i = '0;
    mismatches = 0;
    quiet_cycles = 0;
    no_idle = 1'b0;
    gain_m = GAIN_RESET;
    corr_m = 0;
    sched_time_m = '0;
    sched_per_m = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_smoothing_off();
    test_time_extremes();
    test_loop_gain();
    test_random_traffic();

    drain_results();
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && awaited_outcomes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
